// ===== hdl/bnf_pkg.sv =====
`timescale 1ns / 1ps

package bnf_pkg;

  localparam int ELEM_W  = 10;
  localparam int DATA_W  = 16;
  localparam int BATCH_W = 9;
  localparam int SUM_W   = 24;
  localparam int SQ_W    = 42;
  localparam int STD_W   = SQ_W / 2;

  // Word index of the batch size register on the configuration port.
  localparam logic REG_BATCH_IDX = 1'b0;

  typedef enum logic [1:0] {
    OP_SUM  = 2'd0,
    OP_VAR  = 2'd1,
    OP_NORM = 2'd2,
    OP_LOAD = 2'd3
  } op_e;

  typedef struct packed {
    op_e                      operation;
    logic [ELEM_W-1:0]        element;
    logic                     first_sample;
    logic signed [DATA_W-1:0] sample_value;
    logic signed [DATA_W-1:0] scale_in;
    logic signed [DATA_W-1:0] shift_in;
  } in_item_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] normalized_value;
    logic signed [DATA_W-1:0] scaled_output;
    logic                     saturated;
  } out_item_t;

endpackage

// ===== hdl/bnf_ram.sv =====
`timescale 1ns / 1ps

module bnf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Read returns the old contents when the same address is written.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hdl/bnf_div.sv =====
`timescale 1ns / 1ps

module bnf_div #(
  parameter int NW = 8,
  parameter int DW = 8,
  parameter int QW = 8,
  parameter int SW = 1
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          en_i,
  input  logic          valid_i,
  input  logic [NW-1:0] num_i,
  input  logic [DW-1:0] den_i,
  input  logic [SW-1:0] side_i,
  output logic          valid_o,
  output logic [QW-1:0] quo_o,
  output logic          ovf_o,
  output logic [SW-1:0] side_o
);

  localparam int CW = (NW > DW + QW) ? NW : DW + QW;

  logic          v_q    [QW];
  logic [NW-1:0] rem_q  [QW];
  logic [QW-1:0] quo_q  [QW];
  logic [DW-1:0] den_q  [QW];
  logic          ovf_q  [QW];
  logic [SW-1:0] side_q [QW];

  // One quotient bit per stage, most significant first.
  for (genvar k = 0; k < QW; k++) begin : g_step
    logic          pv;
    logic [NW-1:0] pr;
    logic [QW-1:0] pq;
    logic [DW-1:0] pd;
    logic          po;
    logic [SW-1:0] ps;
    logic [CW-1:0] rx;
    logic [CW-1:0] dx;
    logic          ge;
    logic [QW-1:0] nq;

    if (k == 0) begin : g_first
      assign pv = valid_i;
      assign pr = num_i;
      assign pq = '0;
      assign pd = den_i;
      assign po = CW'(num_i) >= (CW'(den_i) << QW);
      assign ps = side_i;
    end else begin : g_next
      assign pv = v_q[k-1];
      assign pr = rem_q[k-1];
      assign pq = quo_q[k-1];
      assign pd = den_q[k-1];
      assign po = ovf_q[k-1];
      assign ps = side_q[k-1];
    end

    assign rx = CW'(pr);
    assign dx = CW'(pd) << (QW - 1 - k);
    assign ge = rx >= dx;

    always_comb begin
      nq = pq;
      nq[QW-1-k] = ge;
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[k] <= 1'b0;
      end else if (en_i) begin
        v_q[k] <= pv;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[k]  <= ge ? NW'(rx - dx) : pr;
        quo_q[k]  <= nq;
        den_q[k]  <= pd;
        ovf_q[k]  <= po;
        side_q[k] <= ps;
      end
    end
  end

  assign valid_o = v_q[QW-1];
  assign quo_o   = quo_q[QW-1];
  assign ovf_o   = ovf_q[QW-1];
  assign side_o  = side_q[QW-1];

endmodule

// ===== hdl/bnf_sqrt.sv =====
`timescale 1ns / 1ps

module bnf_sqrt #(
  parameter int W  = 42,
  parameter int SW = 1
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           en_i,
  input  logic           valid_i,
  input  logic [W-1:0]   rad_i,
  input  logic [SW-1:0]  side_i,
  output logic           valid_o,
  output logic [W/2-1:0] root_o,
  output logic [SW-1:0]  side_o
);

  localparam int S = W / 2;

  logic          v_q    [S];
  logic [W-1:0]  rad_q  [S];
  logic [W-1:0]  root_q [S];
  logic [SW-1:0] side_q [S];

  // One result bit per stage; the trial bit walks down two places each step.
  for (genvar k = 0; k < S; k++) begin : g_step
    localparam logic [W-1:0] BITC = W'(1) << (W - 2 - 2 * k);

    logic          pv;
    logic [W-1:0]  pa;
    logic [W-1:0]  pr;
    logic [SW-1:0] ps;
    logic [W:0]    trial;
    logic          ge;

    if (k == 0) begin : g_first
      assign pv = valid_i;
      assign pa = rad_i;
      assign pr = '0;
      assign ps = side_i;
    end else begin : g_next
      assign pv = v_q[k-1];
      assign pa = rad_q[k-1];
      assign pr = root_q[k-1];
      assign ps = side_q[k-1];
    end

    assign trial = {1'b0, pr} + {1'b0, BITC};
    assign ge    = {1'b0, pa} >= trial;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[k] <= 1'b0;
      end else if (en_i) begin
        v_q[k] <= pv;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rad_q[k]  <= ge ? W'({1'b0, pa} - trial) : pa;
        root_q[k] <= ge ? ((pr >> 1) + BITC) : (pr >> 1);
        side_q[k] <= ps;
      end
    end
  end

  assign valid_o = v_q[S-1];
  assign root_o  = root_q[S-1][W/2-1:0];
  assign side_o  = side_q[S-1];

endmodule

// ===== hdl/batch_norm_forward.sv =====
`timescale 1ns / 1ps

// Batch normalization forward datapath with one table entry per feature element.
// Items enter on the in_* channel and results leave on the out_* channel; both use
// valid and stall, and an item moves at a clock edge with valid high and stall low.
// A sum pass item and a variance pass item update the element's accumulators, a load
// item writes gamma and beta, and only a normalize pass item produces a result item.
// The batch size register sits on the APB port at word 0 and must be written while idle
// by the user; the block does not enforce this. One item is accepted per cycle while the
// input channel does not stall. A normalize item passes 24 stages that divide the sum by
// the batch size, 42 that divide the square sum, 21 that take the square root, 17 that
// divide by the deviation and seven register stages around the tables and multipliers.
// The whole pipeline moves together; it holds only while a result waits in the
// output register and the receiver stalls, so nothing is lost or repeated.
// After reset a clearing pass writes zero to every gamma and beta entry, one entry a
// cycle, and the input channel stalls until it is done.
// The sum and square sum tables are not cleared: the first sample of each batch
// overwrites them.

module batch_norm_forward #(
  parameter int FEATURE_COUNT = 1024,
  parameter int MAX_BATCH     = 256
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  bnf_pkg::in_item_t   in_item_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output bnf_pkg::out_item_t  out_item_o,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [2:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);

  import bnf_pkg::*;

  localparam int AW     = (FEATURE_COUNT > 1) ? $clog2(FEATURE_COUNT) : 1;
  localparam int NORM_Q = DATA_W + 1;
  localparam int NUM_W  = SUM_W + 8;
  localparam int DEN_W  = STD_W + 1;
  localparam int GB_W   = 2 * DATA_W;

  typedef struct packed {
    op_e                      op;
    logic [ELEM_W-1:0]        element;
    logic                     ok;
    logic                     first;
    logic signed [DATA_W-1:0] x;
    logic signed [DATA_W-1:0] gamma;
    logic signed [DATA_W-1:0] beta;
    logic                     neg;
  } side1_t;

  typedef struct packed {
    op_e                      op;
    logic [ELEM_W-1:0]        element;
    logic                     ok;
    logic                     first;
    logic signed [DATA_W-1:0] gamma;
    logic signed [DATA_W-1:0] beta;
    logic signed [SUM_W:0]    diff;
  } dev_t;

  typedef struct packed {
    op_e                      op;
    logic                     ok;
    logic signed [SUM_W:0]    diff;
    logic signed [DATA_W-1:0] gamma;
    logic signed [DATA_W-1:0] beta;
  } side2_t;

  typedef struct packed {
    op_e                      op;
    logic                     ok;
    logic                     neg;
    logic signed [DATA_W-1:0] gamma;
    logic signed [DATA_W-1:0] beta;
  } side3_t;

  typedef struct packed {
    op_e                      op;
    logic                     ok;
    logic signed [DATA_W-1:0] gamma;
    logic signed [DATA_W-1:0] beta;
    logic signed [DATA_W-1:0] norm;
    logic                     clip;
  } nrm_t;

  typedef struct packed {
    op_e                       op;
    logic                      ok;
    logic signed [DATA_W-1:0]  beta;
    logic signed [DATA_W-1:0]  norm;
    logic                      clip;
    logic signed [GB_W-1:0]    prod;
  } prd_t;

  // Configuration register. The effective batch size clamps zero to one and large
  // values to MAX_BATCH.
  logic [BATCH_W-1:0] batch_q;
  logic [BATCH_W-1:0] eff_batch;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      batch_q <= BATCH_W'(32);
    end else if (psel && penable && pwrite && (paddr[2] == REG_BATCH_IDX)) begin
      batch_q <= pwdata[BATCH_W-1:0];
    end
  end

  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_BATCH_IDX) ? 32'(batch_q) : 32'd0;

  always_comb begin
    if (batch_q == '0) begin
      eff_batch = BATCH_W'(1);
    end else if (batch_q > BATCH_W'(MAX_BATCH)) begin
      eff_batch = BATCH_W'(MAX_BATCH);
    end else begin
      eff_batch = batch_q;
    end
  end

  // Clearing pass over the gamma and beta table after reset.
  logic          clr_busy_q;
  logic [AW-1:0] clr_addr_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_busy_q <= 1'b1;
      clr_addr_q <= '0;
    end else if (clr_busy_q) begin
      clr_addr_q <= clr_addr_q + 1'b1;
      if (clr_addr_q == AW'(FEATURE_COUNT - 1)) begin
        clr_busy_q <= 1'b0;
      end
    end
  end

  // The pipeline advances unless a result waits in the output register and stalls.
  logic out_valid_q;
  logic en;
  logic in_acc;

  assign en         = !out_valid_q || !out_stall_i;
  assign in_stall_o = clr_busy_q || !en;
  assign in_acc     = in_valid_i && !in_stall_o;

  // Stage 1: the accepted item, with the sum and gamma/beta entries read for it.
  logic     st1_v_q;
  in_item_t st1_q;
  logic     st1_ok_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st1_v_q <= 1'b0;
    end else if (en) begin
      st1_v_q <= in_acc;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      st1_q    <= in_item_i;
      st1_ok_q <= {{(17 - ELEM_W){1'b0}}, in_item_i.element} < 17'(FEATURE_COUNT);
    end
  end

  // Sum table. A write lands at the edge at which the next item reads, so the last
  // write is kept and forwarded when the elements match.
  logic [SUM_W-1:0]  sum_rd;
  logic [SUM_W-1:0]  sum_cur;
  logic [SUM_W-1:0]  sum_new;
  logic              sum_wr;
  logic              sum_we;
  logic              lws_v_q;
  logic [ELEM_W-1:0] lws_elem_q;
  logic [SUM_W-1:0]  lws_data_q;

  assign sum_cur = (lws_v_q && (lws_elem_q == st1_q.element)) ? lws_data_q : sum_rd;
  assign sum_new = (st1_q.first_sample ? SUM_W'(0) : sum_cur) + SUM_W'(st1_q.sample_value);
  assign sum_wr  = st1_v_q && st1_ok_q && (st1_q.operation == OP_SUM);
  assign sum_we  = en && sum_wr;

  bnf_ram #(
    .WIDTH (SUM_W),
    .DEPTH (FEATURE_COUNT)
  ) u_sum_ram (
    .clk_i   (clk_i),
    .we_i    (sum_we),
    .waddr_i (AW'(st1_q.element)),
    .wdata_i (sum_new),
    .re_i    (en),
    .raddr_i (AW'(in_item_i.element)),
    .rdata_o (sum_rd)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lws_v_q <= 1'b0;
    end else if (en) begin
      lws_v_q <= sum_wr;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      lws_elem_q <= st1_q.element;
      lws_data_q <= sum_new;
    end
  end

  // Gamma and beta table, packed gamma high and beta low.
  logic [GB_W-1:0]   gb_rd;
  logic [GB_W-1:0]   gb_cur;
  logic              gb_wr;
  logic              gb_we;
  logic [AW-1:0]     gb_waddr;
  logic [GB_W-1:0]   gb_wdata;
  logic              lwg_v_q;
  logic [ELEM_W-1:0] lwg_elem_q;
  logic [GB_W-1:0]   lwg_data_q;

  assign gb_wr    = st1_v_q && st1_ok_q && (st1_q.operation == OP_LOAD);
  assign gb_we    = clr_busy_q || (en && gb_wr);
  assign gb_waddr = clr_busy_q ? clr_addr_q : AW'(st1_q.element);
  assign gb_wdata = clr_busy_q ? GB_W'(0) : {st1_q.scale_in, st1_q.shift_in};
  assign gb_cur   = (lwg_v_q && (lwg_elem_q == st1_q.element)) ? lwg_data_q : gb_rd;

  bnf_ram #(
    .WIDTH (GB_W),
    .DEPTH (FEATURE_COUNT)
  ) u_gb_ram (
    .clk_i   (clk_i),
    .we_i    (gb_we),
    .waddr_i (gb_waddr),
    .wdata_i (gb_wdata),
    .re_i    (en),
    .raddr_i (AW'(in_item_i.element)),
    .rdata_o (gb_rd)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lwg_v_q <= 1'b0;
    end else if (en) begin
      lwg_v_q <= gb_wr;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      lwg_elem_q <= st1_q.element;
      lwg_data_q <= gb_wdata;
    end
  end

  // Mean: the magnitude of the sum is divided by the batch size and the sign restored,
  // which truncates toward zero.
  side1_t           div1_side_in;
  side1_t           div1_side;
  logic [SUM_W-1:0] div1_num;
  logic [SUM_W-1:0] div1_quo;
  logic             div1_v;

  assign div1_num = sum_cur[SUM_W-1] ? (SUM_W'(0) - sum_cur) : sum_cur;

  always_comb begin
    div1_side_in.op      = st1_q.operation;
    div1_side_in.element = st1_q.element;
    div1_side_in.ok      = st1_ok_q;
    div1_side_in.first   = st1_q.first_sample;
    div1_side_in.x       = st1_q.sample_value;
    div1_side_in.gamma   = gb_cur[GB_W-1:DATA_W];
    div1_side_in.beta    = gb_cur[DATA_W-1:0];
    div1_side_in.neg     = sum_cur[SUM_W-1];
  end

  bnf_div #(
    .NW (SUM_W),
    .DW (BATCH_W),
    .QW (SUM_W),
    .SW ($bits(side1_t))
  ) u_mean_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (st1_v_q),
    .num_i   (div1_num),
    .den_i   (eff_batch),
    .side_i  (div1_side_in),
    .valid_o (div1_v),
    .quo_o   (div1_quo),
    .ovf_o   (),
    .side_o  (div1_side)
  );

  // Deviation of the sample from the mean.
  logic signed [SUM_W-1:0] mean;
  logic                    dev_v_q;
  dev_t                    dev_q;

  assign mean = div1_side.neg ? (SUM_W'(0) - div1_quo) : div1_quo;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dev_v_q <= 1'b0;
    end else if (en) begin
      dev_v_q <= div1_v;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      dev_q.op      <= div1_side.op;
      dev_q.element <= div1_side.element;
      dev_q.ok      <= div1_side.ok;
      dev_q.first   <= div1_side.first;
      dev_q.gamma   <= div1_side.gamma;
      dev_q.beta    <= div1_side.beta;
      dev_q.diff    <= (SUM_W + 1)'(div1_side.x) - (SUM_W + 1)'(mean);
    end
  end

  // Squared deviation, kept modulo the square sum width.
  logic [SUM_W-1:0]   dev_mag;
  logic [2*SUM_W-1:0] dev_sq;
  logic               sqs_v_q;
  dev_t               sqs_q;
  logic [SQ_W-1:0]    sqs_sq_q;

  assign dev_mag = dev_q.diff[SUM_W] ? SUM_W'(-dev_q.diff) : SUM_W'(dev_q.diff);
  assign dev_sq  = dev_mag * dev_mag;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sqs_v_q <= 1'b0;
    end else if (en) begin
      sqs_v_q <= dev_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      sqs_q    <= dev_q;
      sqs_sq_q <= dev_sq[SQ_W-1:0];
    end
  end

  // Square sum table, read and written at this one stage with the same forwarding.
  logic [SQ_W-1:0]   sq_rd;
  logic [SQ_W-1:0]   sq_cur;
  logic [SQ_W-1:0]   sq_new;
  logic              sq_wr;
  logic              lwq_v_q;
  logic [ELEM_W-1:0] lwq_elem_q;
  logic [SQ_W-1:0]   lwq_data_q;

  assign sq_cur = (lwq_v_q && (lwq_elem_q == sqs_q.element)) ? lwq_data_q : sq_rd;
  assign sq_new = (sqs_q.first ? SQ_W'(0) : sq_cur) + sqs_sq_q;
  assign sq_wr  = sqs_v_q && sqs_q.ok && (sqs_q.op == OP_VAR);

  bnf_ram #(
    .WIDTH (SQ_W),
    .DEPTH (FEATURE_COUNT)
  ) u_sq_ram (
    .clk_i   (clk_i),
    .we_i    (en && sq_wr),
    .waddr_i (AW'(sqs_q.element)),
    .wdata_i (sq_new),
    .re_i    (en),
    .raddr_i (AW'(dev_q.element)),
    .rdata_o (sq_rd)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lwq_v_q <= 1'b0;
    end else if (en) begin
      lwq_v_q <= sq_wr;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      lwq_elem_q <= sqs_q.element;
      lwq_data_q <= sq_new;
    end
  end

  // Variance, then its integer square root.
  side2_t          div2_side_in;
  side2_t          div2_side;
  side2_t          sqrt_side;
  logic [SQ_W-1:0] var_quo;
  logic            div2_v;
  logic [STD_W-1:0] std_dev;
  logic            sqrt_v;

  always_comb begin
    div2_side_in.op    = sqs_q.op;
    div2_side_in.ok    = sqs_q.ok;
    div2_side_in.diff  = sqs_q.diff;
    div2_side_in.gamma = sqs_q.gamma;
    div2_side_in.beta  = sqs_q.beta;
  end

  bnf_div #(
    .NW (SQ_W),
    .DW (BATCH_W),
    .QW (SQ_W),
    .SW ($bits(side2_t))
  ) u_var_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (sqs_v_q),
    .num_i   (sq_cur),
    .den_i   (eff_batch),
    .side_i  (div2_side_in),
    .valid_o (div2_v),
    .quo_o   (var_quo),
    .ovf_o   (),
    .side_o  (div2_side)
  );

  bnf_sqrt #(
    .W  (SQ_W),
    .SW ($bits(side2_t))
  ) u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (div2_v),
    .rad_i   (var_quo),
    .side_i  (div2_side),
    .valid_o (sqrt_v),
    .root_o  (std_dev),
    .side_o  (sqrt_side)
  );

  // Operands of the normalizing division: |diff| scaled by 256 over std plus one.
  logic [SUM_W-1:0] nd_mag;
  logic             nd_v_q;
  side3_t           nd_side_q;
  logic [NUM_W-1:0] nd_num_q;
  logic [DEN_W-1:0] nd_den_q;

  assign nd_mag = sqrt_side.diff[SUM_W] ? SUM_W'(-sqrt_side.diff) : SUM_W'(sqrt_side.diff);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      nd_v_q <= 1'b0;
    end else if (en) begin
      nd_v_q <= sqrt_v;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      nd_side_q.op    <= sqrt_side.op;
      nd_side_q.ok    <= sqrt_side.ok;
      nd_side_q.neg   <= sqrt_side.diff[SUM_W];
      nd_side_q.gamma <= sqrt_side.gamma;
      nd_side_q.beta  <= sqrt_side.beta;
      nd_num_q        <= {nd_mag, 8'd0};
      nd_den_q        <= {1'b0, std_dev} + DEN_W'(1);
    end
  end

  // The quotient only needs enough bits to decide saturation; larger ones flag overflow.
  side3_t            div3_side;
  logic [NORM_Q-1:0] norm_quo;
  logic              norm_ovf;
  logic              div3_v;

  bnf_div #(
    .NW (NUM_W),
    .DW (DEN_W),
    .QW (NORM_Q),
    .SW ($bits(side3_t))
  ) u_norm_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (nd_v_q),
    .num_i   (nd_num_q),
    .den_i   (nd_den_q),
    .side_i  (nd_side_q),
    .valid_o (div3_v),
    .quo_o   (norm_quo),
    .ovf_o   (norm_ovf),
    .side_o  (div3_side)
  );

  // Signed and saturated normalized value.
  logic signed [DATA_W-1:0] norm_val;
  logic                     norm_clip;
  logic                     nrm_v_q;
  nrm_t                     nrm_q;

  always_comb begin
    norm_clip = 1'b0;
    if (!div3_side.neg) begin
      if (norm_ovf || (norm_quo > NORM_Q'(32767))) begin
        norm_val  = 16'sh7FFF;
        norm_clip = 1'b1;
      end else begin
        norm_val = norm_quo[DATA_W-1:0];
      end
    end else begin
      if (norm_ovf || (norm_quo > NORM_Q'(32768))) begin
        norm_val  = 16'sh8000;
        norm_clip = 1'b1;
      end else begin
        norm_val = DATA_W'(NORM_Q'(0) - norm_quo);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      nrm_v_q <= 1'b0;
    end else if (en) begin
      nrm_v_q <= div3_v;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      nrm_q.op    <= div3_side.op;
      nrm_q.ok    <= div3_side.ok;
      nrm_q.gamma <= div3_side.gamma;
      nrm_q.beta  <= div3_side.beta;
      nrm_q.norm  <= norm_val;
      nrm_q.clip  <= norm_clip;
    end
  end

  // Gamma times the normalized value.
  logic signed [GB_W-1:0] prod;
  logic                   prd_v_q;
  prd_t                   prd_q;

  assign prod = nrm_q.gamma * nrm_q.norm;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prd_v_q <= 1'b0;
    end else if (en) begin
      prd_v_q <= nrm_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      prd_q.op   <= nrm_q.op;
      prd_q.ok   <= nrm_q.ok;
      prd_q.beta <= nrm_q.beta;
      prd_q.norm <= nrm_q.norm;
      prd_q.clip <= nrm_q.clip;
      prd_q.prod <= prod;
    end
  end

  // Floor of the product over 256, plus beta, saturated. Out-of-range elements give
  // an all-zero result.
  logic signed [GB_W-9:0]   prod_q8;
  logic signed [GB_W-8:0]   y_sum;
  logic signed [DATA_W-1:0] y_sat;
  logic                     y_clip;
  out_item_t                out_d;
  out_item_t                out_q;

  assign prod_q8 = prd_q.prod[GB_W-1:8];
  assign y_sum   = (GB_W - 7)'(prod_q8) + (GB_W - 7)'(prd_q.beta);

  always_comb begin
    y_clip = 1'b0;
    if (y_sum > (GB_W - 7)'(32767)) begin
      y_sat  = 16'sh7FFF;
      y_clip = 1'b1;
    end else if (y_sum < -(GB_W - 7)'(32768)) begin
      y_sat  = 16'sh8000;
      y_clip = 1'b1;
    end else begin
      y_sat = y_sum[DATA_W-1:0];
    end
  end

  always_comb begin
    if (prd_q.ok) begin
      out_d.normalized_value = prd_q.norm;
      out_d.scaled_output    = y_sat;
      out_d.saturated        = prd_q.clip || y_clip;
    end else begin
      out_d = '0;
    end
  end

  // Output register: only normalize items leave as result items.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en) begin
      out_valid_q <= prd_v_q && (prd_q.op == OP_NORM);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

`ifndef SYNTHESIS
  a_no_accept_in_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    clr_busy_q |-> !in_acc)
    else $error("item accepted during the table clearing pass");

  a_clear_once: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !clr_busy_q |=> !clr_busy_q)
    else $error("clearing pass restarted without reset");

  a_no_sum_write_in_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    clr_busy_q |-> !sum_we)
    else $error("sum table written during the clearing pass");

  a_norm_reaches_output: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (en && prd_v_q && (prd_q.op == OP_NORM)) |=> out_valid_q)
    else $error("normalize item did not reach the output register");
`endif

endmodule
